// ----- src/pfa_pkg.sv -----
// Shared types, constants and codes for the page frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;

   localparam int MAX_PAGES   = 32768;
   localparam int PAGE_SHIFT  = 12;
   localparam int ADDR_W      = 56;
   localparam int BASE_W      = ADDR_W + 1;
   localparam int IDX_W       = $clog2(MAX_PAGES);
   localparam int CNT_W       = $clog2(MAX_PAGES + 1);
   localparam int REF_W       = 8;
   localparam int FREE_W      = 28;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BASE_W-1:0] PAGE_BYTES = BASE_W'(1) << PAGE_SHIFT;
   localparam logic [BASE_W-1:0] PAGE_MASK  = PAGE_BYTES - BASE_W'(1);
   localparam logic [REF_W-1:0]  REF_MAX    = '1;
   localparam logic [FREE_W-1:0] FREE_MAX   = '1;
   localparam longint FREE_PAGE_LIMIT       = longint'(1) << (FREE_W - PAGE_SHIFT);

   localparam logic [ADDR_W-1:0] HEAP_START_RST = ADDR_W'(64'h8000_0000);
   localparam logic [ADDR_W-1:0] MEM_TOP_RST    = ADDR_W'(64'h8800_0000);

   typedef enum logic [OP_W-1:0] {
      OP_INIT  = 3'd0,
      OP_ALLOC = 3'd1,
      OP_FREE  = 3'd2,
      OP_INC   = 3'd3,
      OP_DEC   = 3'd4,
      OP_QUERY = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_OOM   = 2'd1,
      ST_BAD   = 2'd2,
      ST_LIMIT = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAP_START = 1'b0,
      CSR_MEM_TOP    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_INIT,
      CMD_ALLOC,
      CMD_FREE,
      CMD_INC,
      CMD_DEC,
      CMD_QUERY,
      CMD_BAD
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] page_addr;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   result_addr;
      logic [REF_W-1:0]    ref_count;
      logic [FREE_W-1:0]   free_space;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] pages;
   } cmd_type;

endpackage

// ----- src/pfa_front.sv -----
// Front end: configuration registers, transaction intake and address classification.
`timescale 1ns / 1ps
module pfa_front import pfa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output cmd_type              q_data,
   output logic [BASE_W-1:0]    base
);

   logic [ADDR_W-1:0] heap_start_ff, mem_top_ff;
   logic [BASE_W-1:0] base_ff;
   logic              in_valid_ff, in_valid_in;
   req_type           in_ff;
   logic              accept;

   assign req_stall   = in_valid_ff & q_full;
   assign accept      = req_valid & ~req_stall;
   assign q_push      = in_valid_ff & ~q_full;
   assign in_valid_in = accept | (in_valid_ff & q_full);
   assign base        = base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_start_ff <= HEAP_START_RST;
         mem_top_ff    <= MEM_TOP_RST;
         base_ff       <= BASE_W'(HEAP_START_RST);
         in_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_HEAP_START: begin
                  heap_start_ff <= csr_wdata;
                  base_ff       <= (BASE_W'(csr_wdata) + PAGE_MASK) & ~PAGE_MASK;
               end
               CSR_MEM_TOP: mem_top_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   always_comb begin
      logic [BASE_W-1:0] addr_ext;
      logic [BASE_W-1:0] top_ext;
      logic [BASE_W-1:0] diff;
      logic [BASE_W-1:0] span;
      logic              addr_ok;
      addr_ext = BASE_W'(in_ff.page_addr);
      top_ext  = BASE_W'(mem_top_ff);
      diff     = addr_ext - base_ff;
      addr_ok  = ((addr_ext & PAGE_MASK) == '0)
               && (in_ff.page_addr >= heap_start_ff)
               && (addr_ext >= base_ff)
               && ((addr_ext + PAGE_BYTES) <= top_ext)
               && ((diff >> PAGE_SHIFT) < BASE_W'(MAX_PAGES));
      span     = (top_ext >= base_ff) ? ((top_ext - base_ff) >> PAGE_SHIFT) : '0;
      q_data.idx   = diff[PAGE_SHIFT +: IDX_W];
      q_data.pages = (span > BASE_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : span[CNT_W-1:0];
      unique case (in_ff.op)
         OP_INIT:  q_data.kind = CMD_INIT;
         OP_ALLOC: q_data.kind = CMD_ALLOC;
         OP_FREE:  q_data.kind = addr_ok ? CMD_FREE : CMD_BAD;
         OP_INC:   q_data.kind = addr_ok ? CMD_INC : CMD_BAD;
         OP_DEC:   q_data.kind = addr_ok ? CMD_DEC : CMD_BAD;
         OP_QUERY: q_data.kind = CMD_QUERY;
         default:  q_data.kind = CMD_BAD;
      endcase
   end

endmodule

// ----- src/pfa_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module pfa_queue import pfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_data
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/pfa_back.sv -----
// Back end: free stack and reference count memories, command sequencer, result register.
`timescale 1ns / 1ps
module pfa_back import pfa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cmd_type           q_data,
   output logic              q_pop,
   input  logic [BASE_W-1:0] base,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data
);

   logic [IDX_W-1:0] stack_mem [MAX_PAGES];
   logic [REF_W-1:0] refs_mem  [MAX_PAGES];

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] sweep_ptr_ff, sweep_ptr_in;
   logic [CNT_W-1:0] sweep_n_ff, sweep_n_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] stack_rd_ff;
   logic [REF_W-1:0] ref_rd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             rd_en, commit, out_free;
   logic             stk_we, ref_we;
   logic [IDX_W-1:0] stk_waddr, stk_wdata, stk_raddr, ref_waddr;
   logic [REF_W-1:0] ref_wdata;

   assign out_free     = ~rsp_valid_ff | ~rsp_stall;
   assign stk_raddr    = count_ff[IDX_W-1:0] - IDX_W'(1);
   assign rsp_valid_in = commit | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SWEEP;
         sweep_ptr_ff <= '0;
         sweep_n_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ptr_ff <= sweep_ptr_in;
         sweep_n_ff   <= sweep_n_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (rd_en) begin
         stack_rd_ff <= stack_mem[stk_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         refs_mem[ref_waddr] <= ref_wdata;
      end
      if (rd_en) begin
         ref_rd_ff <= refs_mem[q_data.idx];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_ptr_in = sweep_ptr_ff;
      sweep_n_in   = sweep_n_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      commit       = 1'b0;
      stk_we       = 1'b0;
      stk_waddr    = sweep_ptr_ff;
      stk_wdata    = sweep_ptr_ff;
      ref_we       = 1'b0;
      ref_waddr    = sweep_ptr_ff;
      ref_wdata    = '0;
      rsp_in       = '0;
      rsp_in.status = ST_OK;
      unique case (state_ff)
         BK_SWEEP: begin
            ref_we       = 1'b1;
            stk_we       = (CNT_W'(sweep_ptr_ff) < sweep_n_ff);
            sweep_ptr_in = sweep_ptr_ff + IDX_W'(1);
            if (sweep_ptr_ff == IDX_W'(MAX_PAGES - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = q_data;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = BK_IDLE;
               ref_waddr = cmd_ff.idx;
               unique case (cmd_ff.kind)
                  CMD_INIT: begin
                     state_in     = BK_SWEEP;
                     sweep_ptr_in = '0;
                     sweep_n_in   = cmd_ff.pages;
                     count_in     = cmd_ff.pages;
                  end
                  CMD_ALLOC: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_OOM;
                     end else begin
                        count_in  = count_ff - CNT_W'(1);
                        ref_we    = 1'b1;
                        ref_waddr = stack_rd_ff;
                        ref_wdata = REF_W'(1);
                        rsp_in.result_addr =
                           ADDR_W'(base + (BASE_W'(stack_rd_ff) << PAGE_SHIFT));
                        rsp_in.ref_count = REF_W'(1);
                     end
                  end
                  CMD_FREE: begin
                     if (ref_rd_ff == '0) begin
                        rsp_in.status = ST_BAD;
                     end else if (ref_rd_ff > REF_W'(1)) begin
                        ref_we           = 1'b1;
                        ref_wdata        = ref_rd_ff - REF_W'(1);
                        rsp_in.ref_count = ref_rd_ff - REF_W'(1);
                     end else if (count_ff >= CNT_W'(MAX_PAGES)) begin
                        rsp_in.status    = ST_BAD;
                        rsp_in.ref_count = ref_rd_ff;
                     end else begin
                        ref_we    = 1'b1;
                        ref_wdata = '0;
                        stk_we    = 1'b1;
                        stk_waddr = count_ff[IDX_W-1:0];
                        stk_wdata = cmd_ff.idx;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_INC: begin
                     if (ref_rd_ff == REF_MAX) begin
                        rsp_in.status    = ST_LIMIT;
                        rsp_in.ref_count = ref_rd_ff;
                     end else begin
                        ref_we           = 1'b1;
                        ref_wdata        = ref_rd_ff + REF_W'(1);
                        rsp_in.ref_count = ref_rd_ff + REF_W'(1);
                     end
                  end
                  CMD_DEC: begin
                     if (ref_rd_ff == '0) begin
                        rsp_in.status = ST_LIMIT;
                     end else begin
                        ref_we           = 1'b1;
                        ref_wdata        = ref_rd_ff - REF_W'(1);
                        rsp_in.ref_count = ref_rd_ff - REF_W'(1);
                     end
                  end
                  CMD_QUERY: begin
                     if (longint'(count_ff) >= FREE_PAGE_LIMIT) begin
                        rsp_in.free_space = FREE_MAX;
                     end else begin
                        rsp_in.free_space = FREE_W'(64'(count_ff) << PAGE_SHIFT);
                     end
                  end
                  CMD_BAD: rsp_in.status = ST_BAD;
                  default: rsp_in.status = ST_BAD;
               endcase
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PAGES))
      else $error("free stack count beyond capacity");

   a_alloc_pops: assert property (@(posedge clock) disable iff (reset)
      (commit && cmd_ff.kind == CMD_ALLOC && count_ff != '0)
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("successful alloc did not pop the free stack");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == BK_EXEC))
      else $error("result raised outside command execution");

   a_sweep_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SWEEP && state_in != BK_SWEEP)
      |-> sweep_ptr_ff == IDX_W'(MAX_PAGES - 1))
      else $error("clearing sweep ended early");

endmodule

// ----- src/page_frame_allocator_refcount_unit.sv -----
// Top level of the page frame allocator with per-page reference counts.
`timescale 1ns / 1ps
// Hands out 4 KiB page frames from a LIFO free stack and keeps an 8-bit reference
// count per page. The front end takes one transaction a cycle into a two-entry
// command queue, and stalls while that queue is full; the back end executes one command
// at a time (memory read, then read-modify-write and result load) and takes no new
// command before the last is done. Init sweeps all 32768 entries of the count memory;
// after reset the same clearing pass runs before the first command executes
// (transactions are still queued). A command holds in execution while the result
// register keeps a stalled result. The user must write heap_start and mem_top only
// while the block is idle; the block itself does not enforce this.
module page_frame_allocator_refcount_unit import pfa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   logic              q_push, q_pop, q_full, q_valid;
   cmd_type           push_cmd, pop_cmd;
   logic [BASE_W-1:0] base;

   pfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (push_cmd),
      .base      (base)
   );

   pfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (pop_cmd)
   );

   pfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (pop_cmd),
      .q_pop     (q_pop),
      .base      (base),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
